// ===== hw/rtl/sorted_priority_task_queue_unit_macros.svh =====
// Assertion helpers shared by the queue RTL.
// Both sample on the rising edge of clk and are held off while arst_n is low.
`ifndef SORTED_PRIORITY_TASK_QUEUE_UNIT_MACROS_SVH
`define SORTED_PRIORITY_TASK_QUEUE_UNIT_MACROS_SVH

// Condition that must hold at every clock edge.
`define SPTQ_ASSERT(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define SPTQ_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/sptq_pkg.sv =====
`default_nettype none
package sptq_pkg;

	localparam int CAPACITY = 16;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int ID_W     = 16;
	localparam int PRIO_W   = 8;
	localparam int OUT_CNT_W = 5;

	// Request codes; the fourth code is unused and ignored.
	localparam logic [1:0] REQ_INSERT = 2'd0;
	localparam logic [1:0] REQ_POP    = 2'd1;
	localparam logic [1:0] REQ_REMOVE = 2'd2;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_EMPTY     = 2'd1,
		ST_NOT_FOUND = 2'd2,
		ST_FULL      = 2'd3
	} status_t;

	typedef struct packed {
		logic [ID_W-1:0]   id;
		logic [PRIO_W-1:0] prio;
	} entry_t;

	// Access bundle from the sequencer to the slot memory.
	typedef struct packed {
		logic             wr_en;
		logic [IDX_W-1:0] wr_addr;
		entry_t           wr_data;
		logic             rd_en;
		logic [IDX_W-1:0] rd_addr;
	} mem_req_t;

	// Finished transaction handed to the output register.
	typedef struct packed {
		status_t          status;
		entry_t           removed;
		logic [CNT_W-1:0] count;
	} result_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_INS,
		S_DEL,
		S_DONE
	} seq_state_t;

endpackage
`default_nettype wire

// ===== hw/rtl/sptq_req_if.sv =====
`default_nettype none
interface sptq_req_if;
	import sptq_pkg::*;

	logic              valid;
	logic              ready;
	logic [1:0]        req_type;
	logic [ID_W-1:0]   task_id;
	logic [PRIO_W-1:0] task_priority;

	modport source (output valid, output req_type, output task_id, output task_priority,
		input ready);
	modport sink (input valid, input req_type, input task_id, input task_priority,
		output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/sptq_rsp_if.sv =====
`default_nettype none
interface sptq_rsp_if;
	import sptq_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [1:0]           status;
	logic [ID_W-1:0]      removed_id;
	logic [PRIO_W-1:0]    removed_priority;
	logic [OUT_CNT_W-1:0] entry_count;

	modport source (output valid, output status, output removed_id,
		output removed_priority, output entry_count, input ready);
	modport sink (input valid, input status, input removed_id,
		input removed_priority, input entry_count, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/sptq_ram.sv =====
`default_nettype none
module sptq_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 16,
	localparam int AW = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             wr_en,
	input  wire logic [AW-1:0]    wr_addr,
	input  wire logic [WIDTH-1:0] wr_data,
	input  wire logic             rd_en,
	input  wire logic [AW-1:0]    rd_addr,
	output logic      [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule
`default_nettype wire

// ===== hw/rtl/sptq_seq.sv =====
`default_nettype none
`include "sorted_priority_task_queue_unit_macros.svh"
module sptq_seq (
	input  wire logic              clk,
	input  wire logic              arst_n,
	sptq_req_if.sink               req,
	output sptq_pkg::mem_req_t     mem,
	input  wire sptq_pkg::entry_t  rd_data,
	output logic                   done,
	input  wire logic              take,
	output sptq_pkg::result_t      result
);
	import sptq_pkg::*;

	seq_state_t       state_q, state_d;
	logic [1:0]       req_q;
	entry_t           key_q;
	entry_t           carry_q;
	entry_t           rem_q;
	status_t          status_q;
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] rd_idx_q;
	logic             hit_q;
	logic             vld_s1;
	logic [IDX_W-1:0] idx_s1;

	logic accept;
	logic walking;
	logic rd_go;
	logic pass_end;
	logic ins_place;
	logic del_hit;

	// Decode the walk over slots 0 .. count-1
	always_comb begin
		accept    = (state_q == S_IDLE) && req.valid;
		walking   = (state_q == S_INS) || (state_q == S_DEL);
		rd_go     = walking && (rd_idx_q < cnt_q);
		pass_end  = walking && !vld_s1 && (rd_idx_q == cnt_q);
		ins_place = (state_q == S_INS) && vld_s1 && !hit_q && (rd_data.prio < key_q.prio);
		del_hit   = (state_q == S_DEL) && vld_s1 && !hit_q &&
			((req_q == REQ_POP) || (rd_data.id == key_q.id));
	end

	// Next state, memory accesses and handshakes
	always_comb begin
		state_d     = state_q;
		req.ready   = 1'b0;
		done        = 1'b0;
		mem         = '0;
		mem.rd_en   = rd_go;
		mem.rd_addr = rd_idx_q[IDX_W-1:0];
		result.status  = status_q;
		result.removed = rem_q;
		result.count   = cnt_q;
		case (state_q)
			S_IDLE: begin
				req.ready = 1'b1;
				if (req.valid) begin
					case (req.req_type)
						REQ_INSERT: state_d = (cnt_q == CNT_W'(CAPACITY)) ? S_DONE : S_INS;
						REQ_POP, REQ_REMOVE: state_d = (cnt_q == '0) ? S_DONE : S_DEL;
						default: state_d = S_DONE;
					endcase
				end
			end
			S_INS: begin
				// Shift everything behind the insert point up by one slot
				if (vld_s1 && hit_q) begin
					mem.wr_en   = 1'b1;
					mem.wr_addr = idx_s1;
					mem.wr_data = carry_q;
				end else if (ins_place) begin
					mem.wr_en   = 1'b1;
					mem.wr_addr = idx_s1;
					mem.wr_data = key_q;
				end else if (pass_end) begin
					mem.wr_en   = 1'b1;
					mem.wr_addr = cnt_q[IDX_W-1:0];
					mem.wr_data = hit_q ? carry_q : key_q;
				end
				if (pass_end) begin
					state_d = S_DONE;
				end
			end
			S_DEL: begin
				// Pull every entry behind the hit down by one slot
				if (vld_s1 && hit_q) begin
					mem.wr_en   = 1'b1;
					mem.wr_addr = idx_s1 - IDX_W'(1);
					mem.wr_data = rd_data;
				end
				if (pass_end) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				done = 1'b1;
				if (take) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			cnt_q    <= '0;
			rd_idx_q <= '0;
			hit_q    <= 1'b0;
			vld_s1   <= 1'b0;
			req_q    <= REQ_INSERT;
			status_q <= ST_OK;
		end else begin
			state_q <= state_d;
			if (accept) begin
				req_q    <= req.req_type;
				rd_idx_q <= '0;
				hit_q    <= 1'b0;
				vld_s1   <= 1'b0;
				case (req.req_type)
					REQ_INSERT: status_q <= (cnt_q == CNT_W'(CAPACITY)) ? ST_FULL : ST_OK;
					REQ_POP, REQ_REMOVE: status_q <= (cnt_q == '0) ? ST_EMPTY : ST_OK;
					default: status_q <= ST_OK;
				endcase
			end else if (walking) begin
				vld_s1 <= rd_go;
				if (rd_go) begin
					rd_idx_q <= rd_idx_q + CNT_W'(1);
				end
				if (ins_place || del_hit) begin
					hit_q <= 1'b1;
				end
				if (pass_end) begin
					if (state_q == S_INS) begin
						cnt_q <= cnt_q + CNT_W'(1);
					end else if (hit_q) begin
						cnt_q <= cnt_q - CNT_W'(1);
					end else begin
						status_q <= ST_NOT_FOUND;
					end
				end
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			key_q.id   <= req.task_id;
			key_q.prio <= req.task_priority;
			rem_q      <= '0;
		end else begin
			if (rd_go) begin
				idx_s1 <= rd_idx_q[IDX_W-1:0];
			end
			if ((state_q == S_INS) && vld_s1 && (hit_q || ins_place)) begin
				carry_q <= rd_data;
			end
			if (del_hit) begin
				rem_q <= rd_data;
			end
		end
	end

	`SPTQ_ASSERT(a_cnt_bound, cnt_q <= CNT_W'(CAPACITY), "occupancy above capacity")
	`SPTQ_ASSERT(a_no_rw_clash, !(mem.wr_en && mem.rd_en && (mem.wr_addr == mem.rd_addr)), "read and write hit one slot")
	`SPTQ_ASSERT(a_idle_quiet, (state_q != S_IDLE) || !mem.wr_en, "slot write while idle")
	`SPTQ_ASSERT_NEXT(a_full_refused, accept && (req.req_type == REQ_INSERT) && (cnt_q == CNT_W'(CAPACITY)), (state_q == S_DONE) && (status_q == ST_FULL) && (cnt_q == CNT_W'(CAPACITY)), "insert into full queue not refused")

endmodule
`default_nettype wire

// ===== hw/rtl/sorted_priority_task_queue_unit.sv =====
`default_nettype none
// Channel  Role  Fields
// req      sink  req_type, task_id, task_priority
// rsp      src   status, removed_id, removed_priority, entry_count
//
// Tasks live in one slot memory with a registered read port.
// A request walks the occupied slots one per cycle; a refused, empty or unused request
// skips the walk. rsp.valid rises as the sequencer returns to idle, ready to take the
// next request.
// One request is worked at a time; a new one is taken while the last result waits.
// Reset clears the count and control state, not the slots; a stalled rsp holds the
// sequencer in its final state.
module sorted_priority_task_queue_unit (
	input  wire logic clk,
	input  wire logic arst_n,
	sptq_req_if.sink   req,
	sptq_rsp_if.source rsp
);
	import sptq_pkg::*;

	mem_req_t mem;
	entry_t   rd_data;
	logic     done;
	logic     take;
	result_t  result;

	logic                   out_vld_q;
	status_t                out_status_q;
	entry_t                 out_rem_q;
	logic [OUT_CNT_W-1:0]   out_cnt_q;
	logic [CNT_W+OUT_CNT_W-1:0] cnt_ext;

	sptq_ram #(
		.WIDTH($bits(entry_t)),
		.DEPTH(CAPACITY)
	) u_ram (
		.clk     (clk),
		.wr_en   (mem.wr_en),
		.wr_addr (mem.wr_addr),
		.wr_data (mem.wr_data),
		.rd_en   (mem.rd_en),
		.rd_addr (mem.rd_addr),
		.rd_data (rd_data)
	);

	sptq_seq u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.mem     (mem),
		.rd_data (rd_data),
		.done    (done),
		.take    (take),
		.result  (result)
	);

	// Take a result whenever the output register is free or draining
	assign take    = !out_vld_q || rsp.ready;
	assign cnt_ext = {{OUT_CNT_W{1'b0}}, result.count};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (done && take) begin
			out_vld_q <= 1'b1;
		end else if (rsp.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	// Hold the payload until the transaction completes
	always_ff @(posedge clk) begin
		if (done && take) begin
			out_status_q <= result.status;
			out_rem_q    <= result.removed;
			out_cnt_q    <= cnt_ext[OUT_CNT_W-1:0];
		end
	end

	assign rsp.valid            = out_vld_q;
	assign rsp.status           = out_status_q;
	assign rsp.removed_id       = out_rem_q.id;
	assign rsp.removed_priority = out_rem_q.prio;
	assign rsp.entry_count      = out_cnt_q;

endmodule
`default_nettype wire
